// ----- rtl/mlps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlps_pkg
// Shared sizes and status codes for the min largest partition sum block.
// ----------------------------------------------------------------------------
package mlps_pkg;

  localparam int DEPTH       = 1024;
  localparam int VALUE_WIDTH = 16;

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int K_W     = 11;
  localparam int SUM_W   = 26;
  localparam int STAT_W  = 2;
  localparam int TOT_W   = VALUE_WIDTH + CNT_W;
  localparam int CMP_W   = (CNT_W > K_W) ? CNT_W : K_W;
  localparam int WIDE_W  = (TOT_W > SUM_W) ? TOT_W : SUM_W;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [SUM_W-1:0]       sum_t;
  typedef logic [K_W-1:0]         parts_cfg_t;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_FEW  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

endpackage : mlps_pkg
`default_nettype wire

// ----- rtl/mlps_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlps channel interfaces
// Valid/ready channels for elements, results and the part count register.
// ----------------------------------------------------------------------------
interface mlps_in_if import mlps_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t element_value;
  logic   is_last;

  modport source (output valid, element_value, is_last, input ready);
  modport sink   (input valid, element_value, is_last, output ready);
endinterface : mlps_in_if

interface mlps_out_if import mlps_pkg::*; ();
  logic    valid;
  logic    ready;
  sum_t    min_largest_sum;
  status_t status;

  modport source (output valid, min_largest_sum, status, input ready);
  modport sink   (input valid, min_largest_sum, status, output ready);
endinterface : mlps_out_if

interface mlps_cfg_if import mlps_pkg::*; ();
  logic       valid;
  logic       ready;
  parts_cfg_t part_count;

  modport source (output valid, part_count, input ready);
  modport sink   (input valid, part_count, output ready);
endinterface : mlps_cfg_if
`default_nettype wire

// ----- rtl/mlps_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlps_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : mlps_ram
`default_nettype wire

// ----- rtl/min_largest_partition_sum.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_largest_partition_sum
// Stores a list of elements, then binary-searches the smallest limit at which
// a greedy contiguous split needs at most part_count parts.
// ----------------------------------------------------------------------------
//  channel  dir  word                       handshake
//  din      in   element_value, is_last     valid/ready
//  dout     out  min_largest_sum, status    valid/ready, registered
//  cfg      in   part_count                 valid/ready, always ready
//
//  loading takes one cycle per element; the last element starts the search unless the list overflowed or is too short
//  each search pass is one scan of the n stored elements through the one
//  ram read port plus the adder/compare unit, and the search makes at most
//  about log2(total - max) + 1 passes
//  din is stalled during the search and while a result word waits on dout
//  synchronous reset clears the list state and sets part_count to 1
// ----------------------------------------------------------------------------
module min_largest_partition_sum import mlps_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  mlps_in_if.sink    din,
  mlps_out_if.source dout,
  mlps_cfg_if.sink   cfg
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CHECK,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [TOT_W-1:0]   total;
  value_t             maxv;
  logic               overflow;
  parts_cfg_t         part_count;

  logic [TOT_W-1:0]   lo;
  logic [TOT_W-1:0]   hi;
  logic [TOT_W-1:0]   mid;
  logic [TOT_W-1:0]   acc;
  logic [CNT_W-1:0]   parts;
  logic [CNT_W-1:0]   issue_idx;
  logic               pend;
  logic               pend_first;
  logic               pend_last;

  logic               out_valid;
  sum_t               out_sum;
  status_t            out_status;

  logic               in_fire;
  logic               out_fire;
  logic               has_room;
  logic [CNT_W-1:0]   count_next;
  logic [TOT_W-1:0]   total_next;
  value_t             maxv_next;
  logic               overflow_next;
  parts_cfg_t         k_eff;
  logic               too_few;
  logic               issue;
  value_t             rdata;
  logic [TOT_W:0]     sum_try;
  logic               fits;
  logic               parts_ok;
  logic [TOT_W:0]     mid_sum;
  logic [WIDE_W-1:0]  lo_wide;

  assign din.ready   = (state == ST_LOAD) && !out_valid;
  assign cfg.ready   = 1'b1;
  assign dout.valid  = out_valid;
  assign dout.min_largest_sum = out_sum;
  assign dout.status = out_status;

  assign in_fire  = din.valid && din.ready;
  assign out_fire = out_valid && dout.ready;

  // load bookkeeping
  assign has_room      = count < CNT_W'(DEPTH);
  assign count_next    = count + CNT_W'(has_room);
  assign total_next    = has_room ? total + TOT_W'(din.element_value) : total;
  assign maxv_next     = (has_room && (din.element_value > maxv)) ? din.element_value : maxv;
  assign overflow_next = overflow || !has_room;
  assign k_eff         = (part_count == '0) ? K_W'(1) : part_count;
  assign too_few       = CMP_W'(count_next) < CMP_W'(k_eff);

  // shared unit: greedy accumulate and compare against the trial limit
  assign issue    = (state == ST_SCAN) && (issue_idx < count);
  assign sum_try  = {1'b0, acc} + (TOT_W + 1)'(rdata);
  assign fits     = sum_try <= {1'b0, mid};
  assign parts_ok = CMP_W'(parts) <= CMP_W'(k_eff);
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign lo_wide  = WIDE_W'(lo);

  mlps_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_fire && has_room),
    .waddr (count[ADDR_W-1:0]),
    .wdata (din.element_value),
    .re    (issue),
    .raddr (issue_idx[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      total      <= '0;
      maxv       <= '0;
      overflow   <= 1'b0;
      part_count <= K_W'(1);
      out_valid  <= 1'b0;
      pend       <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        part_count <= cfg.part_count;
      end
      if (out_fire) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_LOAD: begin
          if (in_fire) begin
            if (din.is_last && (overflow_next || too_few)) begin
              out_valid  <= 1'b1;
              out_sum    <= '0;
              out_status <= overflow_next ? STATUS_OVERFLOW : STATUS_TOO_FEW;
              count      <= '0;
              total      <= '0;
              maxv       <= '0;
              overflow   <= 1'b0;
            end else begin
              count    <= count_next;
              total    <= total_next;
              maxv     <= maxv_next;
              overflow <= overflow_next;
              if (din.is_last) begin
                lo    <= TOT_W'(maxv_next);
                hi    <= total_next;
                state <= ST_CHECK;
              end
            end
          end
        end

        ST_CHECK: begin
          if (lo < hi) begin
            mid       <= mid_sum[TOT_W:1];
            issue_idx <= '0;
            pend      <= 1'b0;
            parts     <= CNT_W'(1);
            acc       <= '0;
            state     <= ST_SCAN;
          end else begin
            out_valid  <= 1'b1;
            out_sum    <= lo_wide[SUM_W-1:0];
            out_status <= STATUS_OK;
            count      <= '0;
            total      <= '0;
            maxv       <= '0;
            overflow   <= 1'b0;
            state      <= ST_LOAD;
          end
        end

        ST_SCAN: begin
          // issue the next read; its word is handled in the following cycle
          if (issue) begin
            issue_idx  <= issue_idx + CNT_W'(1);
            pend       <= 1'b1;
            pend_first <= (issue_idx == '0);
            pend_last  <= (issue_idx + CNT_W'(1)) == count;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (pend_first) begin
              acc <= TOT_W'(rdata);
            end else if (fits) begin
              acc <= sum_try[TOT_W-1:0];
            end else begin
              parts <= parts + CNT_W'(1);
              acc   <= TOT_W'(rdata);
            end
            if (pend_last) begin
              state <= ST_DECIDE;
            end
          end
        end

        ST_DECIDE: begin
          if (parts_ok) begin
            hi <= mid;
          end else begin
            lo <= mid + TOT_W'(1);
          end
          state <= ST_CHECK;
        end

        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule : min_largest_partition_sum
`default_nettype wire

// ----- verif/min_largest_partition_sum_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_largest_partition_sum_test
// Loads element lists into the partition search block and scoreboards each
// result word against an in-bench greedy split and binary search. A directed
// list table covers the extremes, the part count register and the store
// capacity; random lists of mixed sizes and value ranges follow. Both sides
// idle at random, and the part count changes only while the block is idle.
// ----------------------------------------------------------------------------
module min_largest_partition_sum_test;
  import mlps_pkg::*;

  typedef enum logic {ROW_PART_COUNT, ROW_ELEMENTS} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    int unsigned value;
    int unsigned reps;
    bit          last;
    bit          typed;
    sum_t        sum;
    status_t     status;
  } stim_row_t;

  typedef struct {
    sum_t    sum;
    status_t status;
  } partition_t;

  logic clk;
  logic rst;
  bit   no_idle;

  mlps_in_if  in_ch ();
  mlps_out_if out_ch ();
  mlps_cfg_if cfg_ch ();

  min_largest_partition_sum dut (
    .clk  (clk),
    .rst  (rst),
    .din  (in_ch),
    .dout (out_ch),
    .cfg  (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // in-bench copy of the list state
  value_t          stored_elems [DEPTH];
  int unsigned     elem_count    = 0;
  longint unsigned list_total    = 0;
  value_t          list_max      = '0;
  bit              list_overflow = 1'b0;
  parts_cfg_t      part_count_reg = 1;

  partition_t awaited_partitions [$];
  int         error_count = 0;
  stim_row_t  stim_rows [$];

  function automatic int unsigned greedy_parts(longint unsigned limit);
    int unsigned     parts;
    longint unsigned acc;
    parts = 1;
    acc   = stored_elems[0];
    for (int unsigned i = 1; i < elem_count; i++) begin
      if (acc + stored_elems[i] <= limit) begin
        acc += stored_elems[i];
      end else begin
        parts++;
        acc = stored_elems[i];
      end
    end
    return parts;
  endfunction

  function automatic bit predict_partition(value_t v, bit last, output partition_t res);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned k;
    res.sum    = '0;
    res.status = STATUS_OK;
    if (elem_count < DEPTH) begin
      stored_elems[elem_count] = v;
      elem_count++;
      list_total += v;
      if (v > list_max) list_max = v;
    end else begin
      list_overflow = 1'b1;
    end
    if (!last) return 1'b0;
    // zero parts acts as one part
    k = (part_count_reg == 0) ? 1 : part_count_reg;
    if (list_overflow) begin
      res.status = STATUS_OVERFLOW;
    end else if (elem_count < k) begin
      res.status = STATUS_TOO_FEW;
    end else begin
      lo = list_max;
      hi = list_total;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (greedy_parts(mid) <= k) hi = mid;
        else lo = mid + 1;
      end
      res.sum = sum_t'(lo);
    end
    elem_count    = 0;
    list_total    = 0;
    list_max      = '0;
    list_overflow = 1'b0;
    return 1'b1;
  endfunction

  function automatic void add_row(row_kind_t kind, int unsigned value, int unsigned reps,
                                  bit last, bit typed, int unsigned sum, status_t status);
    stim_row_t r;
    r.kind    = kind;
    r.value   = value;
    r.reps    = reps;
    r.last    = last;
    r.typed   = typed;
    r.sum     = sum_t'(sum);
    r.status  = status;
    stim_rows = {stim_rows, r};
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_element(value_t v, bit last, bit typed, sum_t sum, status_t status);
    partition_t res;
    while (!no_idle && $urandom_range(0, 99) < 24) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    if (predict_partition(v, last, res)) begin
      if (typed) begin
        res.sum    = sum;
        res.status = status;
      end
      awaited_partitions = {awaited_partitions, res};
    end
    in_ch.valid         <= 1'b1;
    in_ch.element_value <= v;
    in_ch.is_last       <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (awaited_partitions.size() != 0) @(negedge clk);
    // a non-last word may still be settling inside the block
    repeat (8) @(negedge clk);
  endtask

  task automatic write_part_count(int unsigned k);
    drain_results();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.part_count <= parts_cfg_t'(k);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    part_count_reg = parts_cfg_t'(k);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 24);
  end

  always @(posedge clk) begin
    partition_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (awaited_partitions.size() == 0) begin
        if (error_count < 10)
          $display("unexpected result word: sum %0d status %0d",
                   out_ch.min_largest_sum, out_ch.status);
        error_count++;
      end else begin
        want = awaited_partitions.pop_front();
        if (out_ch.min_largest_sum !== want.sum || out_ch.status !== want.status) begin
          if (error_count < 10)
            $display("result mismatch: sum exp %0d got %0d, status exp %0d got %0d",
                     want.sum, out_ch.min_largest_sum, want.status, out_ch.status);
          error_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t   r;
    int unsigned random_items;
    int unsigned random_results;
    int unsigned len;
    int unsigned k;
    int unsigned pick;
    int unsigned mode;
    value_t      v;

    rst                 = 1'b1;
    no_idle             = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.element_value = '0;
    in_ch.is_last       = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.part_count   = '0;
    out_ch.ready        = 1'b0;
    random_items        = 0;
    random_results      = 0;

    // part count is one out of reset: the whole list is one part
    add_row(ROW_ELEMENTS, 0, 1, 1'b1, 1'b1, 0, STATUS_OK);
    add_row(ROW_ELEMENTS, 65535, 1, 1'b1, 1'b1, 65535, STATUS_OK);
    add_row(ROW_ELEMENTS, 65535, 2, 1'b0, 1'b0, 0, STATUS_OK);
    add_row(ROW_ELEMENTS, 0, 1, 1'b1, 1'b1, 131070, STATUS_OK);
    add_row(ROW_PART_COUNT, 3, 0, 1'b0, 1'b0, 0, STATUS_OK);
    add_row(ROW_ELEMENTS, 5, 1, 1'b0, 1'b0, 0, STATUS_OK);
    add_row(ROW_ELEMENTS, 7, 1, 1'b1, 1'b1, 0, STATUS_TOO_FEW);
    for (int unsigned i = 1; i <= 5; i++)
      add_row(ROW_ELEMENTS, i, 1, i == 5, 1'b0, 0, STATUS_OK);
    add_row(ROW_PART_COUNT, 0, 0, 1'b0, 1'b0, 0, STATUS_OK);
    add_row(ROW_ELEMENTS, 10, 1, 1'b0, 1'b0, 0, STATUS_OK);
    add_row(ROW_ELEMENTS, 20, 1, 1'b1, 1'b1, 30, STATUS_OK);
    add_row(ROW_PART_COUNT, 1024, 0, 1'b0, 1'b0, 0, STATUS_OK);
    add_row(ROW_ELEMENTS, 1, 1, 1'b1, 1'b1, 0, STATUS_TOO_FEW);
    add_row(ROW_PART_COUNT, 2, 0, 1'b0, 1'b0, 0, STATUS_OK);
    add_row(ROW_ELEMENTS, 65535, 1, 1'b0, 1'b0, 0, STATUS_OK);
    add_row(ROW_ELEMENTS, 1, 1, 1'b0, 1'b0, 0, STATUS_OK);
    add_row(ROW_ELEMENTS, 65535, 1, 1'b1, 1'b0, 0, STATUS_OK);
    add_row(ROW_ELEMENTS, 0, 2, 1'b1, 1'b1, 0, STATUS_OK);
    add_row(ROW_PART_COUNT, 2047, 0, 1'b0, 1'b0, 0, STATUS_OK);
    add_row(ROW_ELEMENTS, 3, 1, 1'b1, 1'b1, 0, STATUS_TOO_FEW);
    // full store: largest possible sum, then one part per element
    add_row(ROW_PART_COUNT, 1, 0, 1'b0, 1'b0, 0, STATUS_OK);
    add_row(ROW_ELEMENTS, 65535, 1024, 1'b1, 1'b1, 67107840, STATUS_OK);
    add_row(ROW_PART_COUNT, 1024, 0, 1'b0, 1'b0, 0, STATUS_OK);
    add_row(ROW_ELEMENTS, 300, 1023, 1'b0, 1'b0, 0, STATUS_OK);
    add_row(ROW_ELEMENTS, 65535, 1, 1'b1, 1'b1, 65535, STATUS_OK);
    // store overflow wins over too few elements
    add_row(ROW_PART_COUNT, 2047, 0, 1'b0, 1'b0, 0, STATUS_OK);
    add_row(ROW_ELEMENTS, 7, 1027, 1'b1, 1'b1, 0, STATUS_OVERFLOW);
    add_row(ROW_PART_COUNT, 1, 0, 1'b0, 1'b0, 0, STATUS_OK);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (stim_rows[i]) begin
      r = stim_rows[i];
      if (r.kind == ROW_PART_COUNT) begin
        write_part_count(r.value);
      end else begin
        for (int unsigned j = 0; j < r.reps; j++)
          send_element(value_t'(r.value), r.last && (j == r.reps - 1),
                       r.typed, r.sum, r.status);
      end
    end

    while (random_items < 500 || random_results < 40) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) len = $urandom_range(1, 8);
      else if (pick < 95) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 200);

      if ($urandom_range(0, 99) < 30) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) k = $urandom_range(1, len);
        else if (pick < 80) k = $urandom_range(len + 1, len + 4);
        else if (pick < 87) k = 0;
        else if (pick < 93) k = 2047;
        else k = $urandom_range(0, 2047);
        write_part_count(k);
      end else if ($urandom_range(0, 9) == 0) begin
        drain_results();
      end

      // a long stretch with neither side idling
      no_idle = (random_items >= 150 && random_items < 300);
      mode = $urandom_range(0, 3);
      for (int unsigned j = 0; j < len; j++) begin
        case (mode)
          0: v = value_t'($urandom_range(0, 65535));
          1: v = value_t'($urandom_range(0, 15));
          2: begin
            pick = $urandom_range(0, 3);
            v = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1 :
                (pick == 2) ? 16'h8000 : 16'hFFFF;
          end
          default: v = ($urandom_range(0, 3) == 0) ? value_t'($urandom()) : '0;
        endcase
        send_element(v, j == len - 1, 1'b0, '0, STATUS_OK);
        random_items++;
      end
      random_results++;
    end
    no_idle = 1'b0;

    drain_results();
    repeat (64) @(negedge clk);
    if (error_count == 0 && awaited_partitions.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule : min_largest_partition_sum_test

// ----- sim.f -----
rtl/mlps_pkg.sv
rtl/mlps_if.sv
rtl/mlps_ram.sv
rtl/min_largest_partition_sum.sv
verif/min_largest_partition_sum_test.sv
